// ----- hw/rtl/svr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the swept separating-axis ray test.
package svr_pkg;

    localparam int PW = 51;                       // projection width, scale 2^-30
    localparam int NW = PW + 1;                   // numerator width
    localparam logic signed [PW-1:0] EPS_Q30 = PW'(10737);
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [31:0] interval_min;
        logic signed [31:0] interval_max;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_z;
        logic               last_axis;
    } in_item_t;

    typedef struct packed {
        logic        [16:0] hit_fraction;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               collided;
    } out_item_t;

    // Classified axis passed from front to back
    typedef struct packed {
        logic signed [PW-1:0] s;
        logic signed [PW-1:0] d;
        logic signed [PW-1:0] lo;
        logic signed [PW-1:0] hi;
        logic signed [15:0]   nx;
        logic signed [15:0]   ny;
        logic signed [15:0]   nz;
        logic                 sep;
        logic                 tiny;
        logic                 t_gt_hi;
        logic                 last;
    } q_item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_DIV,
        B_APPLY,
        B_DONE
    } back_state_t;

endpackage

// ----- hw/rtl/svr_front.sv -----
`timescale 1ns / 1ps
// Front end: projections, flip and classification of one axis request.
module svr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  svr_pkg::in_item_t item,
    output logic              q_push,
    output svr_pkg::q_item_t  q_item,
    input  logic              q_full
);
    import svr_pkg::*;

    logic advance;
    logic v1_reg, v2_reg;
    logic signed [15:0] ax [3];
    logic signed [31:0] st [3];
    logic signed [31:0] dl [3];
    logic signed [47:0] ps_reg [3];
    logic signed [47:0] pd_reg [3];
    logic signed [15:0] ax1_reg [3];
    logic signed [15:0] ax2_reg [3];
    logic signed [31:0] imin1_reg, imax1_reg, imin2_reg, imax2_reg;
    logic last1_reg, last2_reg;
    logic signed [49:0] s2_reg, d2_reg;
    logic flip;
    logic signed [PW-1:0] sf, df, lo_n, hi_n, lo, hi, t;

    assign ax[0] = item.axis_x;
    assign ax[1] = item.axis_y;
    assign ax[2] = item.axis_z;
    assign st[0] = item.start_x;
    assign st[1] = item.start_y;
    assign st[2] = item.start_z;
    assign dl[0] = item.delta_x;
    assign dl[1] = item.delta_y;
    assign dl[2] = item.delta_z;

    // Whole pipeline holds while the last stage waits on the queue
    assign advance = !(v2_reg && q_full);
    assign full    = !advance;
    assign q_push  = v2_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ps_reg[k]  <= 48'(ax[k]) * 48'(st[k]);
                pd_reg[k]  <= 48'(ax[k]) * 48'(dl[k]);
                ax1_reg[k] <= ax[k];
                ax2_reg[k] <= ax1_reg[k];
            end
            imin1_reg <= item.interval_min;
            imax1_reg <= item.interval_max;
            last1_reg <= item.last_axis;
            imin2_reg <= imin1_reg;
            imax2_reg <= imax1_reg;
            last2_reg <= last1_reg;
            s2_reg <= 50'(ps_reg[0]) + 50'(ps_reg[1]) + 50'(ps_reg[2]);
            d2_reg <= 50'(pd_reg[0]) + 50'(pd_reg[1]) + 50'(pd_reg[2]);
        end
    end

    always_comb
    begin
        flip = d2_reg[49];
        sf   = flip ? -PW'(s2_reg) : PW'(s2_reg);
        df   = flip ? -PW'(d2_reg) : PW'(d2_reg);
        lo_n = PW'(imin2_reg) <<< 14;
        hi_n = PW'(imax2_reg) <<< 14;
        lo   = flip ? -hi_n : lo_n;
        hi   = flip ? -lo_n : hi_n;
        t    = sf + df;

        q_item.s       = sf;
        q_item.d       = df;
        q_item.lo      = lo;
        q_item.hi      = hi;
        // normal is the negated flipped axis
        q_item.nx      = flip ? ax2_reg[0] : -ax2_reg[0];
        q_item.ny      = flip ? ax2_reg[1] : -ax2_reg[1];
        q_item.nz      = flip ? ax2_reg[2] : -ax2_reg[2];
        q_item.sep     = (t < lo) || (sf >= hi);
        q_item.tiny    = (df <= EPS_Q30);
        q_item.t_gt_hi = (t > hi);
        q_item.last    = last2_reg;
    end

endmodule

// ----- hw/rtl/svr_queue.sv -----
`timescale 1ns / 1ps
// Short queue of classified axis requests between front and back.
module svr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  svr_pkg::q_item_t wdata,
    output logic             full,
    input  logic             rd,
    output svr_pkg::q_item_t rdata,
    output logic             empty
);
    import svr_pkg::*;

    q_item_t mem [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;

    assign full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            if (wr && !rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd && !wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wdata;
    end

endmodule

// ----- hw/rtl/svr_back.sv -----
`timescale 1ns / 1ps
// Back end: fraction divider, entry/leave tracking and result register.
module svr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  svr_pkg::q_item_t  q_item,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output svr_pkg::out_item_t result
);
    import svr_pkg::*;

    back_state_t st_reg, st_next;
    q_item_t it_reg, it_next;
    logic phase_reg, phase_next, neg_reg, neg_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [31:0] sh_reg, sh_next, q_reg, q_next;
    logic [4:0] cnt_reg, cnt_next;
    logic signed [31:0] entry_reg, entry_next, leave_reg, leave_next;
    logic signed [15:0] en_reg [3];
    logic signed [15:0] en_next [3];
    logic sep_reg, sep_next;
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic signed [NW-1:0] num;
    logic [NW-1:0] mag, trial, den;
    logic [31:0] lim, rc;
    logic signed [31:0] f, fc;
    logic miss;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_IDLE;
            entry_reg     <= '0;
            leave_reg     <= ONE_Q16;
            sep_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
                en_reg[k] <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            entry_reg     <= entry_next;
            leave_reg     <= leave_next;
            sep_reg       <= sep_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < 3; k++)
                en_reg[k] <= en_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg    <= it_next;
        phase_reg <= phase_next;
        neg_reg   <= neg_next;
        rem_reg   <= rem_next;
        sh_reg    <= sh_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        st_next        = st_reg;
        it_next        = it_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        sh_next        = sh_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        entry_next     = entry_reg;
        leave_next     = leave_reg;
        sep_next       = sep_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        for (int k = 0; k < 3; k++)
            en_next[k] = en_reg[k];
        q_pop = 1'b0;

        den   = NW'(it_reg.d);
        num   = phase_reg ? (NW'(it_reg.hi) - NW'(it_reg.s))
                          : (NW'(it_reg.lo) - NW'(it_reg.s));
        mag   = num[NW-1] ? -num : num;
        trial = {rem_reg[NW-2:0], sh_reg[31]};
        lim   = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        rc    = (q_reg > lim) ? lim : q_reg;
        f     = neg_reg ? -$signed(rc) : $signed(rc);
        miss  = sep_reg || (leave_reg < entry_reg);
        fc    = (entry_reg < 0) ? 32'sd0 : ((entry_reg > ONE_Q16) ? ONE_Q16 : entry_reg);

        unique case (st_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    it_next    = q_item;
                    phase_next = 1'b0;
                    if (sep_reg)
                        st_next = B_DONE;
                    else if (q_item.sep)
                    begin
                        sep_next = 1'b1;
                        st_next  = B_DONE;
                    end
                    else if (q_item.tiny)
                        st_next = B_DONE;
                    else
                        st_next = B_LOAD;
                end
            end
            B_LOAD:
            begin
                neg_next = num[NW-1];
                // a ratio of at least 2^16 overflows the quotient and saturates at once
                if ((16 + NW)'(mag) >= (16 + NW)'({den, 16'h0}))
                begin
                    q_next  = num[NW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    st_next = B_APPLY;
                end
                else
                begin
                    rem_next = NW'(mag[NW-1:16]);
                    sh_next  = {mag[15:0], 16'h0};
                    q_next   = '0;
                    cnt_next = '0;
                    st_next  = B_DIV;
                end
            end
            B_DIV:
            begin
                if (trial >= den)
                begin
                    rem_next = trial - den;
                    q_next   = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    q_next   = {q_reg[30:0], 1'b0};
                end
                sh_next  = {sh_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                    st_next = B_APPLY;
            end
            B_APPLY:
            begin
                if (!phase_reg)
                begin
                    if (f > entry_reg)
                    begin
                        entry_next = f;
                        en_next[0] = it_reg.nx;
                        en_next[1] = it_reg.ny;
                        en_next[2] = it_reg.nz;
                    end
                    if (it_reg.t_gt_hi)
                    begin
                        phase_next = 1'b1;
                        st_next    = B_LOAD;
                    end
                    else
                        st_next = B_DONE;
                end
                else
                begin
                    if (f < leave_reg)
                        leave_next = f;
                    st_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!it_reg.last)
                    st_next = B_IDLE;
                else if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    if (miss)
                    begin
                        out_next.hit_fraction = 17'(ONE_Q16);
                        out_next.normal_x     = '0;
                        out_next.normal_y     = '0;
                        out_next.normal_z     = '0;
                        out_next.collided     = 1'b0;
                    end
                    else
                    begin
                        out_next.hit_fraction = fc[16:0];
                        out_next.normal_x     = en_reg[0];
                        out_next.normal_y     = en_reg[1];
                        out_next.normal_z     = en_reg[2];
                        out_next.collided     = 1'b1;
                    end
                    // clear ray state for the next ray
                    entry_next = '0;
                    leave_next = ONE_Q16;
                    sep_next   = 1'b0;
                    for (int k = 0; k < 3; k++)
                        en_next[k] = '0;
                    st_next = B_IDLE;
                end
            end
            default:
                st_next = B_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/swept_sat_ray_interval_test.sv -----
`timescale 1ns / 1ps
// Top level of the swept separating-axis ray test.
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------
//  input    | push / full      | item   (svr_pkg::in_item_t)
//  result   | pop  / empty     | result (svr_pkg::out_item_t)
//
// The front end is a two-stage projection pipeline feeding a four-entry queue.
// The back end serves one axis at a time through a shared radix-2 divider.
// A separated or tiny axis skips the divider; otherwise the entry fraction is
// divided, and the leave fraction too when t exceeds hi; a saturated quotient
// skips the divider loop, which yields one quotient bit per cycle, 32 bits.
// A last axis holds in the back end while the previous result is still unread.
// Reset clears the ray state to no entry, leave at one, not separated.
// full rises only while the queue is full and the front end holds an axis.
module swept_sat_ray_interval_test (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  svr_pkg::in_item_t  item,
    input  logic               pop,
    output logic               empty,
    output svr_pkg::out_item_t result
);
    import svr_pkg::*;

    q_item_t f_item, b_item;
    logic f_push, q_full, q_empty, q_pop;

    svr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_push (f_push),
        .q_item (f_item),
        .q_full (q_full)
    );

    svr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (f_push),
        .wdata (f_item),
        .full  (q_full),
        .rd    (q_pop),
        .rdata (b_item),
        .empty (q_empty)
    );

    svr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (b_item),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ----- hw/rtl/svr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the swept separating-axis ray test, with its bind.
module svr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               pop,
    input logic               empty,
    input svr_pkg::out_item_t result
);
    import svr_pkg::*;

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed while waiting");

    // a miss reports fraction one and a zero normal
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.collided |->
            result.hit_fraction == 17'd65536 && result.normal_x == 16'sd0 &&
            result.normal_y == 16'sd0 && result.normal_z == 16'sd0)
        else $error("miss result malformed");

    // a hit fraction never exceeds one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.hit_fraction <= 17'd65536)
        else $error("hit fraction above one");

endmodule

bind swept_sat_ray_interval_test svr_checker u_svr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);
